// ----- src/dasp_pkg.sv -----
// shared types, constants and helpers for the two-axis step/direction generator
// no dependencies; imported by dual_axis_step_pulse_generator_top
package dasp_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 24;

    // tick divider register
    localparam int         DIV_W         = 8;
    localparam logic [7:0] TICK_DIV_RST  = 8'd2;

    // toggle count register (signed)
    localparam int CNT_W = 20;

    // rounding offset and saturation for (mag + 100) / 200
    localparam int ROUND_HALF = 100;
    // (mag + 100) at or above this gives a quotient above 262143
    localparam int SAT_LIMIT  = 52428800;
    localparam int SAT_W      = 26;

    // (mag + 100) / 200 = ((mag + 100) >> 3) / 25, done as a reciprocal multiply
    localparam int          QI_LSB     = 3;
    localparam int          QI_W       = 23;
    localparam int          RECIP_W    = 24;
    localparam logic [23:0] DIV_RECIP  = 24'd10737419;
    localparam int          DIV_SHIFT  = 28;
    localparam int          PROD_W     = QI_W + RECIP_W;
    localparam int          Q_W        = 18;
    localparam logic [17:0] Q_MAX      = 18'h3FFFF;

    // input item kinds
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_ZERO = 2'd2
    } t_mode;

    // per-axis data after the rounding stage
    typedef struct packed {
        logic            neg;
        logic            sat;
        logic [QI_W-1:0] quo_in;
    } t_axis_rnd;

    // per-axis data after the multiply stage
    typedef struct packed {
        logic           neg;
        logic           sat;
        logic [Q_W-1:0] quo;
    } t_axis_quo;

    // per-axis motion state
    typedef struct packed {
        logic signed [CNT_W-1:0] cnt;
        logic                    active;
        logic                    step;
        logic                    dir;
    } t_axis_state;

    // one firing tick on one axis
    function automatic t_axis_state fire_axis(input t_axis_state cur, input logic pos_dir);
        t_axis_state nxt;
        nxt = cur;
        if (cur.cnt == '0) begin
            nxt.active = 1'b0;
        end else if (!cur.cnt[CNT_W-1]) begin
            nxt.dir  = pos_dir;
            nxt.step = ~cur.step;
            nxt.cnt  = cur.cnt - CNT_W'(1);
        end else begin
            nxt.dir  = ~pos_dir;
            nxt.step = ~cur.step;
            nxt.cnt  = cur.cnt + CNT_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ----- src/dual_axis_step_pulse_generator_top.sv -----
// two-axis step/direction generator, stream in and stream out
// depends on dasp_pkg
//
// a result passes from its accepted input transaction through the difference register
// (loaded at the accept edge), rounding, reciprocal multiply and the state update
// into the output register; it can leave at the next edge
// throughput: one transaction per cycle; the stages hold only on output back-pressure
// reset: synchronous active-low; references, counts and lines clear, tick divider
// and prescaler return to 2, pipeline empties
module dual_axis_step_pulse_generator_top
    import dasp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: tick divider
    input  logic                 i_cfg_we,
    input  logic [DIV_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata fields from bit 0: target_x, target_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser fields from bit 0: mode
    input  logic [1:0]           s_axis_tuser,
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata fields from bit 0: step_x, dir_x, step_y, dir_y, busy_res, zero fill
    output logic [7:0]           m_axis_tdata
);

    localparam int DW = COORD_BITS + 1;
    localparam int VW = (DW > SAT_W) ? DW : SAT_W;

    // configuration register
    logic [DIV_W-1:0] r_tick_div;

    // reference positions (live at the input stage)
    logic signed [COORD_BITS-1:0] r_ref [2];

    // stage 1: differences
    logic                 r_s1_valid;
    logic [1:0]           r_s1_mode;
    logic signed [DW-1:0] r_s1_diff [2];

    // stage 2: rounded magnitudes
    logic      r_s2_valid;
    logic [1:0] r_s2_mode;
    t_axis_rnd r_s2_axis [2];
    t_axis_rnd n_s2_axis [2];

    // stage 3: quotients
    logic      r_s3_valid;
    logic [1:0] r_s3_mode;
    t_axis_quo r_s3_axis [2];
    t_axis_quo n_s3_axis [2];

    // motion state
    t_axis_state      r_axis [2];
    t_axis_state      n_axis [2];
    logic [DIV_W-1:0] r_prescale;
    logic [DIV_W-1:0] n_prescale;
    logic             r_moving;
    logic             n_moving;

    // output register
    logic       r_out_valid;
    logic [4:0] r_out_data;
    logic [4:0] n_out_data;

    // stage handshake
    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic s_acc;

    logic signed [COORD_BITS-1:0] in_tgt [2];

    assign in_tgt[0] = s_axis_tdata[COORD_BITS-1:0];
    assign in_tgt[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s3_free       = !r_s3_valid || out_free;
    assign s2_free       = !r_s2_valid || s3_free;
    assign s1_free       = !r_s1_valid || s2_free;
    assign s_axis_tready = s1_free;
    assign s_acc         = s_axis_tvalid && s1_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_data};

    // tick divider write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div <= TICK_DIV_RST;
        end else if (i_cfg_we) begin
            r_tick_div <= i_cfg_wdata;
        end
    end

    // stage 1: distance from reference, reference update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_ref[0]   <= '0;
            r_ref[1]   <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s_acc) begin
                case (s_axis_tuser)
                    MODE_LOAD: begin
                        r_ref[0] <= in_tgt[0];
                        r_ref[1] <= in_tgt[1];
                    end
                    MODE_ZERO: begin
                        r_ref[0] <= '0;
                        r_ref[1] <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_mode <= s_axis_tuser;
            for (int a = 0; a < 2; a++) begin
                r_s1_diff[a] <= $signed({in_tgt[a][COORD_BITS-1], in_tgt[a]})
                              - $signed({r_ref[a][COORD_BITS-1], r_ref[a]});
            end
        end
    end

    // stage 2: magnitude plus half divisor, saturation check
    always_comb begin
        logic [DW-1:0] v;
        logic [VW-1:0] v_ext;
        for (int a = 0; a < 2; a++) begin
            n_s2_axis[a].neg    = r_s1_diff[a][DW-1];
            v                   = r_s1_diff[a][DW-1] ? (~r_s1_diff[a] + DW'(ROUND_HALF + 1))
                                                     : (r_s1_diff[a] + DW'(ROUND_HALF));
            v_ext               = VW'(v);
            n_s2_axis[a].sat    = (v_ext >= VW'(SAT_LIMIT));
            n_s2_axis[a].quo_in = v_ext[QI_LSB +: QI_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_mode    <= r_s1_mode;
            r_s2_axis[0] <= n_s2_axis[0];
            r_s2_axis[1] <= n_s2_axis[1];
        end
    end

    // stage 3: divide by 25 through reciprocal multiply
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int a = 0; a < 2; a++) begin
            prod             = PROD_W'(r_s2_axis[a].quo_in) * PROD_W'(DIV_RECIP);
            n_s3_axis[a].neg = r_s2_axis[a].neg;
            n_s3_axis[a].sat = r_s2_axis[a].sat;
            n_s3_axis[a].quo = prod[DIV_SHIFT +: Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && r_s2_valid) begin
            r_s3_mode    <= r_s2_mode;
            r_s3_axis[0] <= n_s3_axis[0];
            r_s3_axis[1] <= n_s3_axis[1];
        end
    end

    // stage 4: motion state update for the item leaving stage 3
    always_comb begin
        logic [Q_W-1:0]   q;
        logic [CNT_W-1:0] cnt2;
        logic [DIV_W-1:0] pre_dec;
        q          = '0;
        cnt2       = '0;
        n_axis[0]  = r_axis[0];
        n_axis[1]  = r_axis[1];
        n_prescale = r_prescale;
        n_moving   = r_moving;
        pre_dec    = r_prescale - DIV_W'(1);
        case (r_s3_mode)
            MODE_TICK: begin
                if (r_moving) begin
                    n_prescale = pre_dec;
                    if (pre_dec == '0) begin
                        n_prescale = r_tick_div;
                        n_axis[0]  = fire_axis(r_axis[0], 1'b0);
                        n_axis[1]  = fire_axis(r_axis[1], 1'b1);
                        if (!n_axis[0].active && !n_axis[1].active) begin
                            n_moving = 1'b0;
                        end
                    end
                end
            end
            MODE_LOAD: begin
                for (int a = 0; a < 2; a++) begin
                    q                = r_s3_axis[a].sat ? Q_MAX : r_s3_axis[a].quo;
                    cnt2             = {1'b0, q, 1'b0};
                    n_axis[a].cnt    = r_s3_axis[a].neg ? -$signed(cnt2) : $signed(cnt2);
                    n_axis[a].active = 1'b1;
                end
                n_moving = 1'b1;
            end
            default: begin
            end
        endcase
        n_out_data = {n_moving, n_axis[1].dir, n_axis[1].step,
                      n_axis[0].dir, n_axis[0].step};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis[0]   <= '0;
            r_axis[1]   <= '0;
            r_prescale  <= TICK_DIV_RST;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s3_valid;
            if (r_s3_valid) begin
                r_axis[0]  <= n_axis[0];
                r_axis[1]  <= n_axis[1];
                r_prescale <= n_prescale;
                r_moving   <= n_moving;
            end
        end
    end

    // result transaction data
    always_ff @(posedge i_clk) begin
        if (out_free && r_s3_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- dv/dual_axis_step_pulse_generator_top_tb.sv -----
// self-checking testbench for the two-axis step/direction generator
// depends on dasp_pkg and dual_axis_step_pulse_generator_top; needs no other files
`timescale 1ns / 1ps

module dual_axis_step_pulse_generator_top_tb
    import dasp_pkg::*;
();

    localparam int          COORD_W      = COORD_BITS_DEF;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam longint      STEP_UNITS   = 200;
    localparam longint      COUNT_SAT    = 524286;
    localparam int          N_DIRECTED   = 25;
    localparam int          PHASE_ITEMS  = 130;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;

    // output lines as packed in m_axis_tdata, step_x in bit 0
    typedef struct packed {
        logic busy;
        logic dir_y;
        logic step_y;
        logic dir_x;
        logic step_x;
    } t_lines;

    typedef struct {
        logic [1:0]         mode;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        bit                 chk;
        t_lines             want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [DIV_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [2*COORD_W-1:0]   s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;

    dual_axis_step_pulse_generator_top #(
        .COORD_BITS(COORD_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // motion tracking state
    logic signed [COORD_W-1:0] trk_ref_x, trk_ref_y;
    t_axis_state               trk_x, trk_y;
    logic [DIV_W-1:0]          trk_presc, trk_div;
    logic                      trk_moving;

    t_lines    lines_due[$];
    t_stim_row directed_rows [N_DIRECTED];
    int        err_count;
    int        result_count;
    int        cycle_count;
    bit        idle_on;
    bit        long_hold_req;
    bit        long_hold_done;
    int        rx_gap;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // toggle count: distance / 200 rounded half away from zero, doubled, saturated
    function automatic logic signed [CNT_W-1:0] axis_toggle_count(
        input logic signed [COORD_W-1:0] tgt,
        input logic signed [COORD_W-1:0] base
    );
        longint span, mag, half;
        span = longint'(tgt) - longint'(base);
        mag  = (span < 0) ? -span : span;
        half = ((mag + STEP_UNITS / 2) / STEP_UNITS) * 2;
        if (half > COUNT_SAT)
            half = COUNT_SAT;
        return CNT_W'((span < 0) ? -half : half);
    endfunction

    // one firing tick on one axis, fwd is the direction level for a positive count
    function automatic t_axis_state advance_axis(input t_axis_state a, input logic fwd);
        t_axis_state n;
        n = a;
        if (a.cnt == '0) begin
            n.active = 1'b0;
        end else begin
            n.step = ~a.step;
            if ($signed(a.cnt) > 0) begin
                n.dir = fwd;
                n.cnt = a.cnt - CNT_W'(1);
            end else begin
                n.dir = ~fwd;
                n.cnt = a.cnt + CNT_W'(1);
            end
        end
        return n;
    endfunction

    // update tracked motion for one accepted transaction and give the expected lines
    task automatic advance_motion(
        input  logic [1:0]         mode,
        input  logic [COORD_W-1:0] tx,
        input  logic [COORD_W-1:0] ty,
        output t_lines             lines
    );
        if (mode == MODE_TICK) begin
            if (trk_moving) begin
                trk_presc = trk_presc - 8'd1;
                if (trk_presc == '0) begin
                    trk_presc = trk_div;
                    trk_x = advance_axis(trk_x, 1'b0);
                    trk_y = advance_axis(trk_y, 1'b1);
                    if (!trk_x.active && !trk_y.active)
                        trk_moving = 1'b0;
                end
            end
        end else if (mode == MODE_LOAD) begin
            trk_x.cnt    = axis_toggle_count(tx, trk_ref_x);
            trk_y.cnt    = axis_toggle_count(ty, trk_ref_y);
            trk_ref_x    = tx;
            trk_ref_y    = ty;
            trk_x.active = 1'b1;
            trk_y.active = 1'b1;
            trk_moving   = 1'b1;
        end else if (mode == MODE_ZERO) begin
            trk_ref_x = '0;
            trk_ref_y = '0;
        end
        lines.busy   = trk_moving;
        lines.dir_y  = trk_y.dir;
        lines.step_y = trk_y.step;
        lines.dir_x  = trk_x.dir;
        lines.step_x = trk_x.step;
    endtask

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch on %s in result %0d: got %b, expected %b",
                 what, result_count, got, want);
        err_count++;
    endtask

    // offer one transaction, called at a falling edge, returns at a falling edge
    task automatic send_item(
        input logic [1:0]         mode,
        input logic [COORD_W-1:0] tx,
        input logic [COORD_W-1:0] ty,
        input bit                 chk,
        input t_lines             want
    );
        t_lines lines;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ty, tx};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        advance_motion(mode, tx, ty, lines);
        lines_due.push_back(chk ? want : lines);
        @(negedge i_clk);
    endtask

    // tick divider write while the block is drained
    task automatic set_tick_divider(input logic [DIV_W-1:0] div);
        s_axis_tvalid <= 1'b0;
        while (lines_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= div;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        trk_div = div;
    endtask

    // one random transaction, mostly ticks and short moves from the current reference
    task automatic send_random(output bit counted);
        int                 pick, delta;
        logic [1:0]         mode;
        logic [COORD_W-1:0] tx, ty;
        pick = $urandom_range(0, 99);
        tx   = COORD_W'($urandom());
        ty   = COORD_W'($urandom());
        if (pick < 60) begin
            mode = MODE_TICK;
        end else if (pick < 78) begin
            mode  = MODE_LOAD;
            delta = int'($urandom_range(0, 2400)) - 1200;
            tx    = COORD_W'(trk_ref_x + delta);
            delta = int'($urandom_range(0, 2400)) - 1200;
            ty    = COORD_W'(trk_ref_y + delta);
        end else if (pick < 84) begin
            mode = MODE_LOAD;
        end else if (pick < 89) begin
            // distances right at a rounding boundary
            mode  = MODE_LOAD;
            delta = int'($urandom_range(0, 4)) * 200 + 99 + int'($urandom_range(0, 2));
            tx    = COORD_W'(trk_ref_x + ($urandom_range(0, 1) ? delta : -delta));
            delta = int'($urandom_range(0, 4)) * 200 + 99 + int'($urandom_range(0, 2));
            ty    = COORD_W'(trk_ref_y + ($urandom_range(0, 1) ? delta : -delta));
        end else if (pick < 93) begin
            mode = MODE_ZERO;
        end else if (pick < 97) begin
            mode = MODE_UNUSED;
        end else begin
            mode = MODE_LOAD;
            tx   = $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
            ty   = $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
        end
        counted = !(mode == MODE_UNUSED || (mode == MODE_TICK && !trk_moving));
        send_item(mode, tx, ty, 1'b0, '0);
    endtask

    // receiver ready: random stall bursts and one long hold-off
    always @(negedge i_clk) begin
        if (rx_gap != 0) begin
            m_axis_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else if (long_hold_req && !long_hold_done) begin
            m_axis_tready <= 1'b0;
            rx_gap = HOLD_CYCLES - 1;
            long_hold_done = 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap = $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expected lines
    always @(posedge i_clk) begin
        t_lines got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_lines'(m_axis_tdata[4:0]);
            if (lines_due.size() == 0) begin
                $display("unexpected result %0d: %b", result_count, m_axis_tdata);
                err_count++;
            end else begin
                want = lines_due.pop_front();
                if (got.step_x !== want.step_x) report_mismatch("step_x", got.step_x, want.step_x);
                if (got.dir_x !== want.dir_x)   report_mismatch("dir_x", got.dir_x, want.dir_x);
                if (got.step_y !== want.step_y) report_mismatch("step_y", got.step_y, want.step_y);
                if (got.dir_y !== want.dir_y)   report_mismatch("dir_y", got.dir_y, want.dir_y);
                if (got.busy !== want.busy)     report_mismatch("busy_res", got.busy, want.busy);
            end
            result_count++;
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial begin
        logic [DIV_W-1:0] phase_div [4];
        bit               counted;
        int               n;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        err_count      = 0;
        result_count   = 0;
        idle_on        = 1'b1;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        rx_gap         = 0;

        trk_ref_x  = '0;
        trk_ref_y  = '0;
        trk_x      = '0;
        trk_y      = '0;
        trk_presc  = TICK_DIV_RST;
        trk_div    = TICK_DIV_RST;
        trk_moving = 1'b0;

        // idle tick, unused mode and origin reset right after reset, then a short
        // move to completion, rounding edges, loads and origin reset during a move
        directed_rows = '{
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b1, 5'b00000},
            '{MODE_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 5'b00000},
            '{MODE_ZERO,   24'h000000, 24'h000000, 1'b1, 5'b00000},
            '{MODE_LOAD,   24'd100,    -24'sd100,  1'b1, 5'b10000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'hFFFFFF, 24'hFFFFFF, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_ZERO,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_LOAD,   24'd99,     -24'sd99,   1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_ZERO,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_LOAD,   24'd299,    -24'sd300,  1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_ZERO,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_LOAD,   24'h7FFFFF, 24'h800000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_LOAD,   24'h800000, 24'h7FFFFF, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_TICK,   24'h000000, 24'h000000, 1'b0, 5'b00000},
            '{MODE_UNUSED, 24'h5A5A5A, 24'hA5A5A5, 1'b0, 5'b00000}
        };

        phase_div[0] = 8'd1;
        phase_div[1] = 8'd255;
        phase_div[2] = DIV_W'($urandom_range(3, 40));
        phase_div[3] = 8'd1;

        // hold reset, then release it
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset divider
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].mode, directed_rows[i].tx, directed_rows[i].ty,
                      directed_rows[i].chk, directed_rows[i].want);

        // random phases, one divider setting each, no idling in the last one
        for (int p = 0; p < 4; p++) begin
            set_tick_divider(phase_div[p]);
            if (p == 3)
                idle_on = 1'b0;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (p == 0 && n == 30)
                    long_hold_req = 1'b1;
                send_random(counted);
                if (counted)
                    n++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (lines_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
